>>> hw/rtl/ssui_pkg.sv
// ----------------------------------------------------------------------------
// ssui_pkg
// Shared constants, codes and beat types of the sorted set union and
// intersection engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ssui_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int DATA_W     = 32;

    localparam logic [1:0] ACT_APPEND_A = 2'd0;
    localparam logic [1:0] ACT_APPEND_B = 2'd1;
    localparam logic [1:0] ACT_RUN      = 2'd2;

    localparam logic MODE_UNION     = 1'b0;
    localparam logic MODE_INTERSECT = 1'b1;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] element;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     is_empty;
        logic                     last_item;
    } out_beat_t;

    typedef struct packed {
        logic      valid;
        out_beat_t beat;
    } push_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/ssui_ram.sv
// ----------------------------------------------------------------------------
// ssui_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ssui_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ssui_ctrl.sv
// ----------------------------------------------------------------------------
// ssui_ctrl
// Load and merge sequencer: appends elements to the two list memories, then
// walks both lists with one read per memory per cycle and emits results.
// ----------------------------------------------------------------------------
`default_nettype none

module ssui_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire ssui_pkg::in_beat_t          s_data,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic                        cfg_wdata,
    input  wire logic                        out_room,
    output ssui_pkg::push_t                  push,
    output ssui_pkg::mem_req_t               req_a,
    output ssui_pkg::mem_req_t               req_b,
    input  wire logic [ssui_pkg::DATA_W-1:0] rd_a,
    input  wire logic [ssui_pkg::DATA_W-1:0] rd_b
);
    import ssui_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                     state_reg, state_next;
    logic                     mode_reg, mode_next;
    logic [CNT_W-1:0]         cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]         cnt_b_reg, cnt_b_next;
    logic [CNT_W-1:0]         i_reg, i_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic                     hold_valid_reg, hold_valid_next;
    logic signed [DATA_W-1:0] hold_val_reg, hold_val_next;

    logic                     a_left, b_left, both, done;
    logic                     emit;
    logic signed [DATA_W-1:0] emit_val, x, y;

    assign x      = $signed(rd_a);
    assign y      = $signed(rd_b);
    assign a_left = i_reg < cnt_a_reg;
    assign b_left = j_reg < cnt_b_reg;
    assign both   = a_left && b_left;
    assign done   = !both && ((mode_reg == MODE_INTERSECT) || (!a_left && !b_left));

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        hold_valid_next = hold_valid_reg;
        hold_val_next   = hold_val_reg;
        emit            = 1'b0;
        emit_val        = x;
        push            = '0;
        req_a           = '0;
        req_b           = '0;
        req_a.waddr     = cnt_a_reg[IDX_W-1:0];
        req_b.waddr     = cnt_b_reg[IDX_W-1:0];
        req_a.wdata     = s_data.element;
        req_b.wdata     = s_data.element;

        if (cfg_valid) begin
            mode_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.action)
                        ACT_APPEND_A: begin
                            if (cnt_a_reg < CNT_W'(LIST_DEPTH)) begin
                                req_a.we   = 1'b1;
                                cnt_a_next = cnt_a_reg + CNT_W'(1);
                            end
                        end
                        ACT_APPEND_B: begin
                            if (cnt_b_reg < CNT_W'(LIST_DEPTH)) begin
                                req_b.we   = 1'b1;
                                cnt_b_next = cnt_b_reg + CNT_W'(1);
                            end
                        end
                        ACT_RUN: begin
                            state_next      = ST_RUN;
                            hold_valid_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (out_room) begin
                    if (done) begin
                        push.valid = 1'b1;
                        if (hold_valid_reg) begin
                            push.beat.result_value = hold_val_reg;
                        end else begin
                            push.beat.is_empty = 1'b1;
                        end
                        push.beat.last_item = 1'b1;
                        state_next          = ST_IDLE;
                        cnt_a_next          = '0;
                        cnt_b_next          = '0;
                        i_next              = '0;
                        j_next              = '0;
                        hold_valid_next     = 1'b0;
                    end else begin
                        priority if (both) begin
                            priority if (x == y) begin
                                emit     = 1'b1;
                                emit_val = x;
                                i_next   = i_reg + CNT_W'(1);
                                j_next   = j_reg + CNT_W'(1);
                            end else if (y < x) begin
                                emit     = (mode_reg == MODE_UNION);
                                emit_val = y;
                                j_next   = j_reg + CNT_W'(1);
                            end else begin
                                emit     = (mode_reg == MODE_UNION);
                                emit_val = x;
                                i_next   = i_reg + CNT_W'(1);
                            end
                        end else if (a_left) begin
                            emit     = 1'b1;
                            emit_val = x;
                            i_next   = i_reg + CNT_W'(1);
                        end else begin
                            emit     = 1'b1;
                            emit_val = y;
                            j_next   = j_reg + CNT_W'(1);
                        end
                        if (emit) begin
                            push.valid             = hold_valid_reg;
                            push.beat.result_value = hold_val_reg;
                            hold_valid_next        = 1'b1;
                            hold_val_next          = emit_val;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        req_a.raddr = i_next[IDX_W-1:0];
        req_b.raddr = j_next[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_UNION;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_val_reg <= hold_val_next;
    end

`ifndef SYNTHESIS
    a_idx_a_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        i_reg <= cnt_a_reg)
        else $error("First list index passed its count.");

    a_idx_b_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        j_reg <= cnt_b_reg)
        else $error("Second list index passed its count.");

    a_cnt_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_a_reg <= CNT_W'(LIST_DEPTH)) && (cnt_b_reg <= CNT_W'(LIST_DEPTH)))
        else $error("A list count exceeds the list depth.");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid && push.beat.last_item |=>
            (state_reg == ST_IDLE) && (cnt_a_reg == '0) && (cnt_b_reg == '0))
        else $error("The last beat of a run did not return to idle with cleared counts.");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid && push.beat.is_empty |-> push.beat.last_item)
        else $error("An empty result beat is not marked last.");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/sorted_set_union_intersection_top.sv
// ----------------------------------------------------------------------------
// sorted_set_union_intersection_top
// Loads two signed lists into two RAMs and streams their union or intersection
// via an output register, at most one result beat per cycle unless stalled.
//
// Channel   Ports                         Beat
// input     s_valid, s_ready, s_data      action, element
// result    m_valid, m_ready, m_data      result_value, is_empty, last_item
// config    cfg_valid, cfg_ready, cfg_wdata  set_mode
//
// Loads stream at one beat per cycle while s_ready is high.
// A run is a series of walk steps, at most the sum of both counts, plus
// one closing step; each step is one read of each list RAM.
// s_ready stays low while a run is in progress, and the walk pauses while
// the output register is full and m_ready is low.
// Reset clears the counts, the mode and the sequencer; list contents are
// not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_set_union_intersection_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ssui_pkg::in_beat_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ssui_pkg::out_beat_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_wdata
);
    import ssui_pkg::*;

    mem_req_t          req_a, req_b;
    logic [DATA_W-1:0] rd_a, rd_b;
    push_t             push;
    logic              out_room;

    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_data_reg, out_data_next;

    ssui_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram_a (
        .aclk  (aclk),
        .we    (req_a.we),
        .waddr (req_a.waddr),
        .wdata (req_a.wdata),
        .raddr (req_a.raddr),
        .rdata (rd_a)
    );

    ssui_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram_b (
        .aclk  (aclk),
        .we    (req_b.we),
        .waddr (req_b.waddr),
        .wdata (req_b.wdata),
        .raddr (req_b.raddr),
        .rdata (rd_b)
    );

    ssui_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata),
        .out_room  (out_room),
        .push      (push),
        .req_a     (req_a),
        .req_b     (req_b),
        .rd_a      (rd_a),
        .rd_b      (rd_b)
    );

    assign out_room = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        if (push.valid) begin
            out_valid_next = 1'b1;
            out_data_next  = push.beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire
